// ===== hw/rtl/llrs_pkg.sv =====
// ----------------------------------------------------------------------------
// llrs_pkg
// Shared types and constants for the life-like automaton row step core.
// ----------------------------------------------------------------------------
package llrs_pkg;

  localparam int unsigned ROW_CELLS_DEF = 64;
  localparam int unsigned COL_W         = 7;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 7;
  localparam int unsigned OUT_DEPTH     = 4;

  localparam logic [COL_W-1:0] COLUMNS_RST   = 7'd64;
  localparam logic [CNT_W-1:0] SURV_MIN_RST  = 4'd3;
  localparam logic [CNT_W-1:0] SURV_MAX_RST  = 4'd6;
  localparam logic [CNT_W-1:0] BIRTH_RST     = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS  = 3'd0,
    CFG_SURV_MIN = 3'd1,
    CFG_SURV_MAX = 3'd2,
    CFG_BIRTH    = 3'd3
  } llrs_cfg_e;

  typedef struct packed {
    logic [CNT_W-1:0] surv_min;
    logic [CNT_W-1:0] surv_max;
    logic [CNT_W-1:0] birth;
  } llrs_rule_t;

  // which of the two possible results of one item go into the queue
  typedef struct packed {
    logic held;   // result for the held middle row
    logic last;   // result for the item's own row, grid ends here
  } llrs_push_t;

endpackage

// ===== hw/rtl/llrs_lane.sv =====
// ----------------------------------------------------------------------------
// llrs_lane
// One cell: counts the eight neighbours and applies the birth/survive rule.
// ----------------------------------------------------------------------------
module llrs_lane
  import llrs_pkg::*;
(
  input  logic [2:0]  above_i,
  input  logic [2:0]  here_i,
  input  logic [2:0]  below_i,
  input  llrs_rule_t  rule_i,
  output logic        alive_o
);

  logic [CNT_W-1:0] count;

  assign count = CNT_W'(above_i[0]) + CNT_W'(above_i[1]) + CNT_W'(above_i[2])
               + CNT_W'(here_i[0])  + CNT_W'(here_i[2])
               + CNT_W'(below_i[0]) + CNT_W'(below_i[1]) + CNT_W'(below_i[2]);

  always_comb begin
    if (here_i[1]) begin
      alive_o = (count >= rule_i.surv_min) && (count <= rule_i.surv_max);
    end else begin
      alive_o = (count == rule_i.birth);
    end
  end

endmodule

// ===== hw/rtl/llrs_row_calc.sv =====
// ----------------------------------------------------------------------------
// llrs_row_calc
// Row of cell lanes over a three-row window, merged into one masked row.
// ----------------------------------------------------------------------------
module llrs_row_calc
  import llrs_pkg::*;
#(
  parameter int unsigned ROW_CELLS = ROW_CELLS_DEF
) (
  input  logic [ROW_CELLS-1:0] above_i,
  input  logic [ROW_CELLS-1:0] here_i,
  input  logic [ROW_CELLS-1:0] below_i,
  input  logic [ROW_CELLS-1:0] mask_i,
  input  llrs_rule_t           rule_i,
  output logic [ROW_CELLS-1:0] next_o
);

  // dead cell padded on both sides
  logic [ROW_CELLS+1:0] above_pad;
  logic [ROW_CELLS+1:0] here_pad;
  logic [ROW_CELLS+1:0] below_pad;
  logic [ROW_CELLS-1:0] lane_alive;

  assign above_pad = {1'b0, above_i & mask_i, 1'b0};
  assign here_pad  = {1'b0, here_i  & mask_i, 1'b0};
  assign below_pad = {1'b0, below_i & mask_i, 1'b0};

  for (genvar i = 0; i < ROW_CELLS; i++) begin : g_lane
    llrs_lane u_lane (
      .above_i (above_pad[i+2:i]),
      .here_i  (here_pad[i+2:i]),
      .below_i (below_pad[i+2:i]),
      .rule_i  (rule_i),
      .alive_o (lane_alive[i])
    );
  end

  assign next_o = lane_alive & mask_i;

endmodule

// ===== hw/rtl/llrs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// llrs_out_fifo
// Small result queue, takes up to two results a cycle and gives one when read.
// ----------------------------------------------------------------------------
module llrs_out_fifo
  import llrs_pkg::*;
#(
  parameter int unsigned ROW_CELLS = ROW_CELLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  llrs_push_t           push_i,
  input  logic [ROW_CELLS-1:0] held_cells_i,
  input  logic [ROW_CELLS-1:0] last_cells_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [ROW_CELLS-1:0] cells_o,
  output logic                 final_o
);

  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_Q = $clog2(OUT_DEPTH + 1);

  logic [ROW_CELLS-1:0] cells_q [OUT_DEPTH];
  logic                 fin_q   [OUT_DEPTH];
  logic [PTR_W-1:0]     rd_q, rd_d;
  logic [PTR_W-1:0]     wr_q, wr_d;
  logic [CNT_Q-1:0]     count_q, count_d;
  logic [1:0]           n_push;
  logic                 pop;

  assign n_push  = {1'b0, push_i.held} + {1'b0, push_i.last};
  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (count_q < CNT_Q'(OUT_DEPTH - 1));
  assign cells_o = cells_q[rd_q];
  assign final_o = fin_q[rd_q];

  assign rd_d    = rd_q + PTR_W'(pop);
  assign wr_d    = wr_q + PTR_W'(n_push);
  assign count_d = count_q + CNT_Q'(n_push) - CNT_Q'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  // held result always goes ahead of the last-row result
  always_ff @(posedge clk_i) begin
    if (push_i.held) begin
      cells_q[wr_q] <= held_cells_i;
      fin_q[wr_q]   <= 1'b0;
      if (push_i.last) begin
        cells_q[wr_q + PTR_W'(1)] <= last_cells_i;
        fin_q[wr_q + PTR_W'(1)]   <= 1'b1;
      end
    end else if (push_i.last) begin
      cells_q[wr_q] <= last_cells_i;
      fin_q[wr_q]   <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/life_like_automaton_row_step_core.sv =====
// Each row's result is queued as the row below it, or a last row itself, is accepted.
// Throughput: one row per cycle while the result queue has room for two results.
// A last row after a held row gives two results; the queue drains one a cycle if read.
// Reset: held rows and the result queue clear, the rule goes to birth 4, survive 3..6,
// and the row width to 64 columns.
// ----------------------------------------------------------------------------
// life_like_automaton_row_step_core
// Next generation of a life-like automaton, one grid row per item.
// ----------------------------------------------------------------------------
module life_like_automaton_row_step_core
  import llrs_pkg::*;
#(
  parameter int unsigned ROW_CELLS = ROW_CELLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ROW_CELLS-1:0]  row_cells_i,
  input  logic                  last_row_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROW_CELLS-1:0]  next_cells_o,
  output logic                  final_row_o
);

  logic [COL_W-1:0]     columns_q;
  llrs_rule_t           rule_q;
  logic [ROW_CELLS-1:0] upper_q, upper_d;
  logic [ROW_CELLS-1:0] middle_q, middle_d;
  logic                 mvalid_q, mvalid_d;

  logic [ROW_CELLS-1:0] mask;
  logic [ROW_CELLS-1:0] row_in;
  logic [ROW_CELLS-1:0] upper_next;
  logic [ROW_CELLS-1:0] held_cells;
  logic [ROW_CELLS-1:0] last_cells;
  logic                 room;
  logic                 accept;
  llrs_push_t           push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q       <= COLUMNS_RST;
      rule_q.surv_min <= SURV_MIN_RST;
      rule_q.surv_max <= SURV_MAX_RST;
      rule_q.birth    <= BIRTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COLUMNS:  columns_q       <= cfg_data_i[COL_W-1:0];
        CFG_SURV_MIN: rule_q.surv_min <= cfg_data_i[CNT_W-1:0];
        CFG_SURV_MAX: rule_q.surv_max <= cfg_data_i[CNT_W-1:0];
        CFG_BIRTH:    rule_q.birth    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // widths beyond the row size leave every column in use
  for (genvar i = 0; i < ROW_CELLS; i++) begin : g_mask
    assign mask[i] = (COL_W'(i) < columns_q);
  end

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;
  assign row_in     = row_cells_i & mask;
  assign upper_next = mvalid_q ? middle_q : '0;

  assign push.held = accept && mvalid_q;
  assign push.last = accept && last_row_i;

  llrs_row_calc #(
    .ROW_CELLS (ROW_CELLS)
  ) u_calc_held (
    .above_i (upper_q),
    .here_i  (middle_q),
    .below_i (row_in),
    .mask_i  (mask),
    .rule_i  (rule_q),
    .next_o  (held_cells)
  );

  llrs_row_calc #(
    .ROW_CELLS (ROW_CELLS)
  ) u_calc_last (
    .above_i (upper_next),
    .here_i  (row_in),
    .below_i ('0),
    .mask_i  (mask),
    .rule_i  (rule_q),
    .next_o  (last_cells)
  );

  always_comb begin
    upper_d  = upper_q;
    middle_d = middle_q;
    mvalid_d = mvalid_q;
    if (accept) begin
      if (last_row_i) begin
        upper_d  = '0;
        middle_d = '0;
        mvalid_d = 1'b0;
      end else begin
        upper_d  = upper_next;
        middle_d = row_in;
        mvalid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      middle_q <= '0;
      mvalid_q <= 1'b0;
    end else begin
      upper_q  <= upper_d;
      middle_q <= middle_d;
      mvalid_q <= mvalid_d;
    end
  end

  llrs_out_fifo #(
    .ROW_CELLS (ROW_CELLS)
  ) u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .held_cells_i (held_cells),
    .last_cells_i (last_cells),
    .room_o       (room),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .cells_o      (next_cells_o),
    .final_o      (final_row_o)
  );

endmodule

// ===== hw/rtl/llrs_checker.sv =====
// ----------------------------------------------------------------------------
// llrs_checker
// Port-level checks for the row step core, attached by bind.
// ----------------------------------------------------------------------------
module llrs_checker
  import llrs_pkg::*;
#(
  parameter int unsigned ROW_CELLS = ROW_CELLS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 last_row_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ROW_CELLS-1:0] next_cells_o,
  input logic                 final_row_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(next_cells_o)
                                       && $stable(final_row_o)))
    else $error("result item changed while stalled");

  // a last row always leaves a result behind it
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_row_i) |=> out_valid_o)
    else $error("no result after last row");

  // input back-pressure only comes from a queue holding results
  a_stall_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with nothing to deliver");

  // results never appear without an item going in
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an accepted item");

endmodule

bind life_like_automaton_row_step_core llrs_checker #(
  .ROW_CELLS (ROW_CELLS)
) u_llrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_row_i   (last_row_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .next_cells_o (next_cells_o),
  .final_row_o  (final_row_o)
);
